### src/lir_pkg.sv
// ============================================================================
// lir_pkg: shared types and constants of the linear interpolation resampler
// Item formats, register indexes, datapath widths and controller links.
// ============================================================================
`default_nettype none

package lir_pkg;

    localparam int FRAC_BITS   = 12;
    localparam int SAMPLE_BITS = 16;
    localparam int STEP_BITS   = 20;
    localparam int CFG_BITS    = 20;
    localparam int MAX_RESULTS = 64;
    localparam int COUNT_BITS  = $clog2(MAX_RESULTS);
    localparam int SKIP_BITS   = 8;
    localparam int CARRY_BITS  = STEP_BITS + 1 - FRAC_BITS;
    localparam int DIFF_BITS   = SAMPLE_BITS + 1;
    localparam int PROD_BITS   = DIFF_BITS + FRAC_BITS + 1;

    localparam logic [STEP_BITS-1:0] STEP_RESET  = STEP_BITS'(4096);
    localparam logic [FRAC_BITS-1:0] START_RESET = '0;
    localparam logic [SKIP_BITS-1:0] SKIP_MAX    = '1;

    typedef enum logic [0:0] {
        REG_STEP_INCREMENT = 1'b0,
        REG_START_FRACTION = 1'b1
    } cfg_index_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample_in;
        logic                          restart;
    } src_item_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample_out;
        logic                          last_of_run;
    } dst_item_t;

    // controller -> datapath
    typedef struct packed {
        logic accept;   // take the source item this cycle
        logic emit;     // compute one result into the output register
    } lir_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic needs_run;  // current source item yields results
        logic last;       // result computed this cycle ends the run
        logic out_free;   // output register can load this cycle
    } lir_status_t;

endpackage

`default_nettype wire

### src/lir_ctrl.sv
// ============================================================================
// lir_ctrl: resampler sequencer
// Accepts source items and steps the datapath through one run of results.
// ============================================================================
`default_nettype none

module lir_ctrl (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  src_valid,
    output logic                 src_stall,
    input  lir_pkg::lir_status_t status,
    output lir_pkg::lir_cmd_t    cmd
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        cmd.accept = (state_reg == ST_IDLE) && src_valid;
        cmd.emit   = (state_reg == ST_RUN) && status.out_free;
        src_stall  = (state_reg != ST_IDLE);
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd.accept && status.needs_run)
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (cmd.emit && status.last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

### src/lir_datapath.sv
// ============================================================================
// lir_datapath: resampler state, interpolator and output register
// History, phase, skip count, run counter and one multiply per result.
// ============================================================================
`default_nettype none

module lir_datapath (
    input  wire                                   clk,
    input  wire                                   rst_n,
    input  lir_pkg::lir_cmd_t                     cmd,
    output lir_pkg::lir_status_t                  status,
    input  lir_pkg::src_item_t                    src_item,
    input  wire                                   cfg_write,
    input  lir_pkg::cfg_index_t                   cfg_index,
    input  wire [lir_pkg::CFG_BITS-1:0]           cfg_data,
    output logic                                  dst_valid,
    input  wire                                   dst_stall,
    output lir_pkg::dst_item_t                    dst_item
);

    logic [lir_pkg::STEP_BITS-1:0]          step_reg;
    logic [lir_pkg::FRAC_BITS-1:0]          start_reg;

    logic signed [lir_pkg::SAMPLE_BITS-1:0] prev_reg, prev_next;
    logic signed [lir_pkg::SAMPLE_BITS-1:0] cur_reg, cur_next;
    logic                                   hist_reg, hist_next;
    logic [lir_pkg::FRAC_BITS-1:0]          phase_reg, phase_next;
    logic [lir_pkg::SKIP_BITS-1:0]          skip_reg, skip_next;
    logic [lir_pkg::COUNT_BITS-1:0]         count_reg, count_next;
    logic                                   out_valid_reg, out_valid_next;
    lir_pkg::dst_item_t                     out_item_reg, out_item_next;

    logic signed [lir_pkg::DIFF_BITS-1:0]   diff;
    logic signed [lir_pkg::PROD_BITS-1:0]   prod;
    logic signed [lir_pkg::PROD_BITS-1:0]   interp;
    logic [lir_pkg::STEP_BITS:0]            acc;
    logic [lir_pkg::CARRY_BITS-1:0]         carry;
    logic [lir_pkg::CARRY_BITS-1:0]         extra;
    logic [lir_pkg::SKIP_BITS-1:0]          skip_sat;

    // one result: prev + floor((cur - prev) * frac / 2^FRAC_BITS)
    always_comb
    begin
        diff   = lir_pkg::DIFF_BITS'(cur_reg) - lir_pkg::DIFF_BITS'(prev_reg);
        prod   = diff * $signed({1'b0, phase_reg});
        interp = lir_pkg::PROD_BITS'(prev_reg) + (prod >>> lir_pkg::FRAC_BITS);
        acc    = {1'b0, step_reg} + (lir_pkg::STEP_BITS + 1)'(phase_reg);
        carry  = acc[lir_pkg::STEP_BITS:lir_pkg::FRAC_BITS];
        extra  = carry - lir_pkg::CARRY_BITS'(1);
        if (extra > lir_pkg::CARRY_BITS'(lir_pkg::SKIP_MAX))
        begin
            skip_sat = lir_pkg::SKIP_MAX;
        end
        else
        begin
            skip_sat = extra[lir_pkg::SKIP_BITS-1:0];
        end
    end

    always_comb
    begin
        status.needs_run = !src_item.restart && hist_reg && (skip_reg == '0);
        status.last      = (carry != '0) ||
                           (count_reg == lir_pkg::COUNT_BITS'(lir_pkg::MAX_RESULTS - 1));
        status.out_free  = !out_valid_reg || !dst_stall;
    end

    always_comb
    begin
        prev_next      = prev_reg;
        cur_next       = cur_reg;
        hist_next      = hist_reg;
        phase_next     = phase_reg;
        skip_next      = skip_reg;
        count_next     = count_reg;
        out_item_next  = out_item_reg;
        out_valid_next = out_valid_reg && dst_stall;

        if (cmd.accept)
        begin
            priority if (src_item.restart || !hist_reg)
            begin
                // prime history
                prev_next = src_item.sample_in;
                hist_next = 1'b1;
                if (src_item.restart)
                begin
                    phase_next = start_reg;
                    skip_next  = '0;
                end
            end
            else if (skip_reg != '0)
            begin
                skip_next = skip_reg - lir_pkg::SKIP_BITS'(1);
                prev_next = src_item.sample_in;
            end
            else
            begin
                cur_next   = src_item.sample_in;
                count_next = '0;
            end
        end

        if (cmd.emit)
        begin
            out_valid_next           = 1'b1;
            out_item_next.sample_out = interp[lir_pkg::SAMPLE_BITS-1:0];
            out_item_next.last_of_run = status.last;
            phase_next               = acc[lir_pkg::FRAC_BITS-1:0];
            count_next               = count_reg + lir_pkg::COUNT_BITS'(1);
            if (status.last)
            begin
                prev_next = cur_reg;
                if (carry != '0)
                begin
                    skip_next = skip_sat;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= lir_pkg::STEP_RESET;
            start_reg     <= lir_pkg::START_RESET;
            prev_reg      <= '0;
            hist_reg      <= 1'b0;
            phase_reg     <= lir_pkg::START_RESET;
            skip_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                unique case (cfg_index)
                    lir_pkg::REG_STEP_INCREMENT:
                    begin
                        step_reg <= cfg_data[lir_pkg::STEP_BITS-1:0];
                    end
                    lir_pkg::REG_START_FRACTION:
                    begin
                        start_reg <= cfg_data[lir_pkg::FRAC_BITS-1:0];
                    end
                    default:
                    begin
                    end
                endcase
            end
            prev_reg      <= prev_next;
            hist_reg      <= hist_next;
            phase_reg     <= phase_next;
            skip_reg      <= skip_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg      <= cur_next;
        out_item_reg <= out_item_next;
    end

    assign dst_valid = out_valid_reg;
    assign dst_item  = out_item_reg;

    // pending skips only exist once history is primed
    a_skip_needs_hist: assert property (@(posedge clk) disable iff (!rst_n)
        (skip_reg != '0) |-> hist_reg)
        else $error("skip count set without history");

    // a run never goes past the result limit without ending
    a_run_limit: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit && (count_reg == lir_pkg::COUNT_BITS'(lir_pkg::MAX_RESULTS - 1)))
        |=> (dst_valid && dst_item.last_of_run))
        else $error("run exceeded result limit");

    // an emitted result reaches the output register
    a_emit_loads: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |=> dst_valid)
        else $error("emitted result not presented");

endmodule

`default_nettype wire

### src/linear_interp_resampler_unit.sv
// ============================================================================
// linear_interp_resampler_unit: streaming linear-interpolation resampler
// Fixed-point phase accumulator; during a run one result per unstalled cycle.
// ============================================================================
// Each source item is paired with the one before it. While the phase still
// points into that pair the block emits prev + floor((cur - prev) * frac /
// 4096), then adds step_increment to the phase; a carry moves to the next
// pair, and a carry above one drops that many extra source items (at most
// 255). The first item after reset and every item with restart set only
// primes the history. A primed or dropped item is accepted and starts no run.
// An item that produces N results (1 to 64, set by step_increment and the
// current phase) is accepted, then yields one result per cycle through the
// single shared 17x13 multiplier, given no stall at the result
// side. The source side stalls while a run is in progress; the output
// register lets the next item be accepted while the last result still waits.
// Registers: index 0 step_increment (reset 4096), index 1 start_fraction
// (reset 0, used at the next restart). Write only while the block is idle.
// ============================================================================
`default_nettype none

module linear_interp_resampler_unit (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          src_valid,
    output logic                         src_stall,
    input  lir_pkg::src_item_t           src_item,
    output logic                         dst_valid,
    input  wire                          dst_stall,
    output lir_pkg::dst_item_t           dst_item,
    input  wire                          cfg_write,
    input  lir_pkg::cfg_index_t          cfg_index,
    input  wire [lir_pkg::CFG_BITS-1:0]  cfg_data
);

    lir_pkg::lir_cmd_t    cmd;
    lir_pkg::lir_status_t status;

    // sequencer: accept and emit decisions
    lir_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (src_valid),
        .src_stall (src_stall),
        .status    (status),
        .cmd       (cmd)
    );

    // state, interpolator, output register, configuration
    lir_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .src_item  (src_item),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .dst_valid (dst_valid),
        .dst_stall (dst_stall),
        .dst_item  (dst_item)
    );

endmodule

`default_nettype wire

### sim/resample_check_pkg.sv
// ============================================================================
// resample_check_pkg: result predictor and scoreboard for the resampler bench
// Tracks phase, history and skip count, queues expected output items in
// order, and compares each output item against the oldest expectation.
// ============================================================================
`default_nettype none

package resample_check_pkg;

    timeunit 1ns;
    timeprecision 1ps;

    import lir_pkg::*;

    class resample_scoreboard;

        // register copies
        logic [STEP_BITS-1:0]          step_inc;
        logic [FRAC_BITS-1:0]          start_frac;

        // interpolator state
        logic signed [SAMPLE_BITS-1:0] prev_sample;
        bit                            primed;
        logic [FRAC_BITS-1:0]          phase;
        logic [SKIP_BITS-1:0]          skip_left;

        dst_item_t                     expected_q[$];
        int                            errors;
        int                            items_noted;
        int                            results_checked;

        function new();
            step_inc        = STEP_RESET;
            start_frac      = START_RESET;
            prev_sample     = '0;
            primed          = 1'b0;
            phase           = START_RESET;
            skip_left       = '0;
            errors          = 0;
            items_noted     = 0;
            results_checked = 0;
        endfunction

        function void set_register(cfg_index_t idx, logic [CFG_BITS-1:0] data);
            case (idx)
                REG_STEP_INCREMENT: step_inc   = data[STEP_BITS-1:0];
                REG_START_FRACTION: start_frac = data[FRAC_BITS-1:0];
                default: ;
            endcase
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // One accepted source item: update state, queue the outputs it causes.
        function void note_input(src_item_t it);
            logic signed [SAMPLE_BITS-1:0] cur;
            longint                        diff;
            longint                        interp;
            logic [STEP_BITS:0]            acc;
            logic [CARRY_BITS-1:0]         carry;
            dst_item_t                     want;
            int                            n;
            bit                            done;

            cur = it.sample_in;
            items_noted++;
            if (it.restart)
            begin
                phase       = start_frac;
                prev_sample = '0;
                primed      = 1'b0;
                skip_left   = '0;
            end
            if (!primed)
            begin
                prev_sample = cur;
                primed      = 1'b1;
                return;
            end
            if (skip_left != 0)
            begin
                skip_left--;
                prev_sample = cur;
                return;
            end

            n    = 0;
            done = 1'b0;
            while (!done)
            begin
                diff   = longint'(cur) - longint'(prev_sample);
                // arithmetic shift = floor toward minus infinity
                interp = longint'(prev_sample) + ((diff * longint'(phase)) >>> FRAC_BITS);
                acc    = phase + step_inc;
                carry  = acc[STEP_BITS:FRAC_BITS];
                phase  = acc[FRAC_BITS-1:0];
                n++;
                if (carry != 0)
                begin
                    skip_left = (carry - 1 > SKIP_MAX) ? SKIP_MAX : SKIP_BITS'(carry - 1);
                    done      = 1'b1;
                end
                else if (n == MAX_RESULTS)
                begin
                    done = 1'b1;
                end
                want.sample_out  = interp[SAMPLE_BITS-1:0];
                want.last_of_run = done;
                expected_q.push_back(want);
            end
            prev_sample = cur;
        endfunction

        function void check_result(dst_item_t got);
            dst_item_t want;

            results_checked++;
            if (expected_q.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("ERROR: unexpected output item sample_out=%0d last_of_run=%0b",
                             got.sample_out, got.last_of_run);
                return;
            end
            want = expected_q.pop_front();
            if (got.sample_out !== want.sample_out || got.last_of_run !== want.last_of_run)
            begin
                errors++;
                if (errors <= 10)
                    $display("ERROR: output %0d: sample_out exp %0d got %0d, last_of_run exp %0b got %0b",
                             results_checked, want.sample_out, got.sample_out,
                             want.last_of_run, got.last_of_run);
            end
        endfunction

    endclass

endpackage

`default_nettype wire

### sim/tb.sv
// ============================================================================
// tb: bench for the linear interpolation resampler
// Directed corner items, then randomized phases over several step and start
// settings with random source gaps and output stalls; every output item is
// checked against a cycle-free predictor held in the scoreboard.
// ============================================================================
`default_nettype none

module tb;

    timeunit 1ns;
    timeprecision 1ps;

    import lir_pkg::*;
    import resample_check_pkg::*;

    // quiet cycles before the run is declared hung; the longest legal quiet
    // stretch is the idle pause between phases plus a long output stall streak
    localparam int STALL_LIMIT  = 4000;
    // pause after draining, meant to outlast the longest run
    localparam int DRAIN_CYCLES = 80;
    localparam int NUM_PHASES   = 8;
    localparam int PHASE_ITEMS  = 25;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 src_valid = 1'b0;
    logic                 src_stall;
    src_item_t            src_item  = '0;
    logic                 dst_valid;
    logic                 dst_stall = 1'b0;
    dst_item_t            dst_item;
    logic                 cfg_write = 1'b0;
    cfg_index_t           cfg_index = REG_STEP_INCREMENT;
    logic [CFG_BITS-1:0]  cfg_data  = '0;

    resample_scoreboard   sb;

    int                   src_idle_pct  = 0;
    int                   dst_stall_pct = 0;
    int                   quiet_cycles  = 0;

    linear_interp_resampler_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (src_valid),
        .src_stall (src_stall),
        .src_item  (src_item),
        .dst_valid (dst_valid),
        .dst_stall (dst_stall),
        .dst_item  (dst_item),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Output side: stall decided at the falling edge, item taken at the rising
    // edge (values seen there are the ones from before the edge).
    always @(negedge clk)
        dst_stall <= ($urandom_range(0, 99) < dst_stall_pct);

    always @(posedge clk)
        if (rst_n && dst_valid && !dst_stall)
            sb.check_result(dst_item);

    // Hang detector: any handshake or register write counts as progress.
    always @(posedge clk)
    begin
        if ((src_valid && !src_stall) || (dst_valid && !dst_stall) || cfg_write || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("ERROR: no handshake for %0d cycles, %0d output items outstanding",
                     STALL_LIMIT, sb.pending());
            $display("TB_ERROR");
            $finish;
        end
    end

    // mode 0 none, 1 source gaps, 2 output stalls, 3 both
    task set_idling(input int mode);
        case (mode)
            1:       begin src_idle_pct = 60; dst_stall_pct = 0;  end
            2:       begin src_idle_pct = 0;  dst_stall_pct = 60; end
            3:       begin src_idle_pct = 37; dst_stall_pct = 37; end
            default: begin src_idle_pct = 0;  dst_stall_pct = 0;  end
        endcase
    endtask

    // Called at a falling edge; returns at the falling edge after acceptance.
    // valid is only written once per step: lowered during a gap, raised for
    // the item, and left high into the next call.
    task send_sample(input logic signed [SAMPLE_BITS-1:0] smp, input logic rst_hist);
        src_item_t it;

        it.sample_in = smp;
        it.restart   = rst_hist;
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            src_valid <= 1'b0;
            @(negedge clk);
        end
        src_valid <= 1'b1;
        src_item  <= it;
        do
            @(posedge clk);
        while (src_stall);
        sb.note_input(it);
        @(negedge clk);
    endtask

    // Let everything expected come out, then allow the block to finish any
    // run that produced nothing visible yet.
    task drain;
        src_valid <= 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task write_reg(input cfg_index_t idx, input logic [CFG_BITS-1:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        sb.set_register(idx, data);
    endtask

    task configure(input logic [STEP_BITS-1:0] step, input logic [FRAC_BITS-1:0] start);
        drain();
        write_reg(REG_STEP_INCREMENT, CFG_BITS'(step));
        write_reg(REG_START_FRACTION, CFG_BITS'(start));
        cfg_write <= 1'b0;
        @(negedge clk);
    endtask

    initial
    begin
        logic [STEP_BITS-1:0]          step;
        logic [FRAC_BITS-1:0]          start;
        logic signed [SAMPLE_BITS-1:0] smp;
        int                            restart_pct;
        int                            pick;

        sb = new();
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // ---------------- directed part ----------------
        set_idling(1);

        // reset settings: step 1.0, phase 0 -> one output per pair, equal to prev
        send_sample(-16'sd32768, 1'b0);     // first item only primes history
        send_sample(16'sd32767, 1'b0);      // full-scale swing up
        send_sample(-16'sd32768, 1'b0);     // and down
        send_sample(16'sd0, 1'b1);          // restart mid-stream: primes again
        send_sample(-16'sd1, 1'b0);

        // start phase at its top value, half step: largest products, 1-2 outputs
        configure(20'd2048, 12'd4095);
        send_sample(16'sd32767, 1'b1);
        send_sample(-16'sd32768, 1'b0);
        send_sample(16'sd32767, 1'b0);
        send_sample(-16'sd32768, 1'b0);

        // smallest legal step: 64 outputs from one pair, carry on the last
        configure(20'd64, 12'd0);
        send_sample(16'sd100, 1'b1);
        send_sample(-16'sd32768, 1'b0);
        send_sample(16'sd32767, 1'b0);

        // zero step: output capped at the run limit, phase stays where it is
        configure(20'd0, 12'd1);
        send_sample(16'sd5, 1'b1);
        send_sample(-16'sd7, 1'b0);
        send_sample(16'sd32767, 1'b0);

        // largest step: one output then a saturated skip count; restart clears it
        configure(20'hFFFFF, 12'd4095);
        send_sample(16'sd1, 1'b1);
        send_sample(16'sd2, 1'b0);
        send_sample(16'sd3, 1'b0);          // dropped by the skip counter
        send_sample(16'sd4, 1'b1);
        send_sample(16'sd5, 1'b0);

        // carry of two: every other item dropped
        configure(20'd8292, 12'd0);
        send_sample(16'sd10, 1'b1);
        send_sample(16'sd20, 1'b0);
        send_sample(16'sd30, 1'b0);
        send_sample(16'sd40, 1'b0);

        // ---------------- random phases ----------------
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            restart_pct = 4;
            start       = FRAC_BITS'($urandom_range(0, 4095));
            case (p)
                0: begin step = 20'd64; start = '0; end
                1:
                begin
                    // outputs are rare here, restart often to get more of them
                    step        = 20'hFFFFF;
                    start       = '1;
                    restart_pct = 35;
                end
                2: step = STEP_BITS'($urandom_range(65, 4095));
                3: step = STEP_BITS'($urandom_range(4096, 12288));
                4: step = STEP_RESET;
                5: step = STEP_BITS'($urandom_range(4097, 40000));
                6: step = STEP_BITS'($urandom_range(64, 2048));
                default: step = STEP_BITS'($urandom_range(0, 63));
            endcase
            configure(step, start);
            set_idling(p % 4);

            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 3)
                    smp = 16'sh7FFF;
                else if (pick < 6)
                    smp = 16'sh8000;
                else if (pick < 9)
                    smp = 16'sh0000;
                else if (pick < 12)
                    smp = 16'shFFFF;
                else
                    smp = SAMPLE_BITS'($urandom);
                // first item of a phase restarts half the time so the new
                // start fraction gets picked up
                send_sample(smp, (i == 0) ? ($urandom_range(0, 1) == 1)
                                          : ($urandom_range(0, 99) < restart_pct));
            end
        end

        drain();

        $display("Resampler run: %0d source items, %0d output items checked over %0d settings",
                 sb.items_noted, sb.results_checked, NUM_PHASES + 6);
        $display("Covered priming, restart, skipping, run cap and full-scale samples; %0d errors",
                 sb.errors);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

`default_nettype wire
